### sv/a429e_pkg.sv
// Package for the ARINC 429 data word encoder.
// Holds the widths, word constants, action and state codes and the parity helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package a429e_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_DIGITS = 8;

  localparam int VAL_W      = 32;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int WORD_W     = 24;
  localparam int FIELD_W    = 4 * MAX_DIGITS;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int TOTAL_W    = 5;
  localparam int SCALE_SH   = FRAC_BITS + 16;
  localparam int RECIP_SH   = 35;

  localparam logic [WORD_W-1:0] BNR_MARK = 24'h600000;
  localparam logic [WORD_W-1:0] BCD_MASK = 24'h1FFFFC;
  localparam logic [VAL_W-1:0]  DEG_RECIP = 32'd95443927;
  localparam logic [VAL_W-1:0]  RECIP10   = 32'hCCCCCCCD;
  localparam logic [3:0]        NIBBLE    = 4'hF;

  typedef enum logic [1:0] {
    ACT_BNR  = 2'd0,
    ACT_DEG  = 2'd1,
    ACT_BCD6 = 2'd2,
    ACT_BCD2 = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_SCALE = 5'b00100,
    S_DIGIT = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  // Scale factor for the first pass through the multiplier; the product is
  // always taken from bit SCALE_SH upward.
  function automatic logic [VAL_W-1:0] scale_factor(input action_e act, input logic [1:0] fd);
    logic [VAL_W-1:0] p10;
    begin
      case (fd)
        2'd0:    p10 = 32'd1;
        2'd1:    p10 = 32'd10;
        2'd2:    p10 = 32'd100;
        2'd3:    p10 = 32'd1000;
        default: p10 = 32'd1;
      endcase
      case (act)
        ACT_DEG: scale_factor = DEG_RECIP;
        ACT_BNR: scale_factor = 32'd1 << 16;
        default: scale_factor = p10 << 16;
      endcase
    end
  endfunction

  // Set bit 23 when label plus word bits 22..0 hold an even number of ones.
  function automatic logic [WORD_W-1:0] add_parity(input logic [WORD_W-1:0] w,
                                                   input logic [7:0] lbl);
    logic even;
    begin
      even = ~(^{lbl, w[WORD_W-2:0]});
      add_parity = {w[WORD_W-1] | even, w[WORD_W-2:0]};
    end
  endfunction

endpackage

`default_nettype wire

### sv/a429e_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on a429e_pkg for operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module a429e_mul (
  input  wire logic                             clk_i,
  input  wire logic [a429e_pkg::VAL_W-1:0]      a_i,
  input  wire logic [a429e_pkg::VAL_W-1:0]      b_i,
  output      logic [a429e_pkg::PROD_W-1:0]     p_o
);

  logic [a429e_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### sv/arinc429_data_word_encoder_top.sv
// Top level of the ARINC 429 data word encoder: sequencer, digit datapath, output register.
// Depends on a429e_pkg and a429e_mul.
`timescale 1ns / 1ps
`default_nettype none

// An item is taken when start is high and busy is low; busy then stays high
// until the word is out. The encoded word appears on arinc_word_o for one
// cycle with done_o high, and there is no way to hold it off. All work goes
// through one registered multiplier: a scaling pass, then for BCD one digit
// per cycle (multiply by the reciprocal of ten). After the accepting edge an
// item passes through S_MUL, S_SCALE, for BCD one S_DIGIT step per digit
// (n digits, 1..8), and S_DONE, which registers the word and the strobe; a
// new item can be taken at the edge that ends the strobe cycle, not before.
module arinc429_data_word_encoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  action_i,
  input  wire logic signed [31:0] value_fixed_i,
  input  wire logic [3:0]  int_digits_i,
  input  wire logic [1:0]  frac_digits_i,
  input  wire logic [7:0]  label_i,
  output      logic [23:0] arinc_word_o,
  output      logic        done_o
);

  localparam int VAL_W   = a429e_pkg::VAL_W;
  localparam int PROD_W  = a429e_pkg::PROD_W;
  localparam int WORD_W  = a429e_pkg::WORD_W;
  localparam int FIELD_W = a429e_pkg::FIELD_W;
  localparam int CNT_W   = a429e_pkg::CNT_W;
  localparam int IDX_W   = a429e_pkg::IDX_W;
  localparam int TOTAL_W = a429e_pkg::TOTAL_W;

  a429e_pkg::state_e  state_q, state_d;
  a429e_pkg::action_e act_q;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   idx_q, idx_d;

  logic [VAL_W-1:0]   mag_q, mag_d;
  logic [VAL_W-1:0]   k_q, k_d;
  logic [VAL_W-1:0]   work_q, work_d;
  logic [FIELD_W-1:0] field_q, field_d;
  logic               neg_q, neg_d;
  logic [7:0]         label_q, label_d;
  logic [WORD_W-1:0]  word_q, word_d;

  logic [VAL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic [VAL_W-1:0]   scaled, quot, times10, bnr_t;
  logic [3:0]         digit, nib;
  logic [TOTAL_W-1:0] total;
  logic [CNT_W-1:0]   count;
  logic [VAL_W-1:0]   raw;
  logic [WORD_W-1:0]  pre_word;
  logic               accept;

  a429e_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign raw     = value_fixed_i;
  assign accept  = start && !busy;
  assign scaled  = prod[a429e_pkg::SCALE_SH +: VAL_W];
  assign quot    = VAL_W'(prod >> a429e_pkg::RECIP_SH);
  assign times10 = (quot << 3) + (quot << 1);
  assign digit   = 4'(work_q - times10);
  assign nib     = neg_q ? (4'(4'd0 - digit) & a429e_pkg::NIBBLE) : digit;
  assign total   = TOTAL_W'(int_digits_i) + TOTAL_W'(frac_digits_i);
  assign bnr_t   = neg_q ? (VAL_W'(0) - work_q) : work_q;

  always_comb begin
    if (total == '0) begin
      count = CNT_W'(1);
    end else if (total > TOTAL_W'(a429e_pkg::MAX_DIGITS)) begin
      count = CNT_W'(a429e_pkg::MAX_DIGITS);
    end else begin
      count = CNT_W'(total);
    end
  end

  always_comb begin
    case (act_q)
      a429e_pkg::ACT_BNR,
      a429e_pkg::ACT_DEG:  pre_word = {bnr_t[WORD_W-3:0], 2'b00} | a429e_pkg::BNR_MARK;
      a429e_pkg::ACT_BCD6: pre_word = WORD_W'(field_q << 6) & a429e_pkg::BCD_MASK;
      a429e_pkg::ACT_BCD2: pre_word = WORD_W'(field_q << 2) & a429e_pkg::BCD_MASK;
      default:             pre_word = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    mag_d   = mag_q;
    k_d     = k_q;
    work_d  = work_q;
    field_d = field_q;
    neg_d   = neg_q;
    label_d = label_q;
    word_d  = word_q;
    mul_a   = mag_q;
    mul_b   = k_q;
    case (state_q)
      a429e_pkg::S_IDLE: begin
        if (accept) begin
          neg_d   = raw[VAL_W-1];
          mag_d   = raw[VAL_W-1] ? (~raw + VAL_W'(1)) : raw;
          k_d     = a429e_pkg::scale_factor(a429e_pkg::action_e'(action_i), frac_digits_i);
          label_d = label_i;
          cnt_d   = count;
          idx_d   = '0;
          field_d = '0;
          state_d = a429e_pkg::S_MUL;
        end
      end
      a429e_pkg::S_MUL: begin
        state_d = a429e_pkg::S_SCALE;
      end
      a429e_pkg::S_SCALE: begin
        work_d = scaled;
        mul_a  = scaled;
        mul_b  = a429e_pkg::RECIP10;
        if (act_q == a429e_pkg::ACT_BNR || act_q == a429e_pkg::ACT_DEG) begin
          state_d = a429e_pkg::S_DONE;
        end else begin
          state_d = a429e_pkg::S_DIGIT;
        end
      end
      a429e_pkg::S_DIGIT: begin
        field_d = field_q | (FIELD_W'(nib) << {idx_q, 2'b00});
        work_d  = quot;
        mul_a   = quot;
        mul_b   = a429e_pkg::RECIP10;
        idx_d   = idx_q + IDX_W'(1);
        cnt_d   = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = a429e_pkg::S_DONE;
        end
      end
      a429e_pkg::S_DONE: begin
        word_d  = a429e_pkg::add_parity(pre_word, label_q);
        done_d  = 1'b1;
        state_d = a429e_pkg::S_IDLE;
      end
      default: begin
        state_d = a429e_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= a429e_pkg::S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= a429e_pkg::action_e'(action_i);
    end
    mag_q   <= mag_d;
    k_q     <= k_d;
    work_q  <= work_d;
    field_q <= field_d;
    neg_q   <= neg_d;
    label_q <= label_d;
    word_q  <= word_d;
  end

  assign busy         = (state_q != a429e_pkg::S_IDLE);
  assign done_o       = done_q;
  assign arinc_word_o = word_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_done_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == a429e_pkg::S_DONE))
    else $error("result strobe without finishing step");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == a429e_pkg::S_DIGIT) |-> (cnt_q != '0))
    else $error("digit step with no digits left");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy)
    else $error("result strobe while busy");

endmodule

`default_nettype wire

### bench/arinc429_word_checker.sv
// Word checker for the ARINC 429 data word encoder bench.
// Watches the item and word channels, predicts each encoded word and compares it.
// Depends on a429e_pkg.
`timescale 1ns / 1ps

module arinc429_word_checker
  import a429e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] value_fixed_i,
  input  logic [3:0]  int_digits_i,
  input  logic [1:0]  frac_digits_i,
  input  logic [7:0]  label_i,
  input  logic [23:0] arinc_word_i,
  input  logic        done_i,
  output int          err_cnt_o,
  output int          pending_o,
  output int          words_o
);

  localparam logic [63:0] DEG_COUNT_RECIP = 64'd95443927;

  logic [23:0] word_q[$];
  logic [23:0] want;

  function automatic logic [23:0] encode_word(input action_e act, input logic [31:0] raw,
                                              input logic [3:0] id, input logic [1:0] fd,
                                              input logic [7:0] lbl);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] whole;
    logic [63:0] work;
    logic [63:0] field;
    logic [63:0] nib;
    logic [63:0] p10;
    logic [63:0] placed;
    logic [23:0] w;
    int          ndig;
    int          k;
    begin
      neg = raw[31];
      mag = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
      case (act)
        ACT_BNR, ACT_DEG: begin
          if (act == ACT_BNR) whole = mag >> FRAC_BITS;
          else whole = (mag * DEG_COUNT_RECIP) >> (FRAC_BITS + 16);
          if (neg) whole = 64'd0 - whole;
          w = {whole[21:0], 2'b00} | 24'h600000;
        end
        default: begin
          case (fd)
            2'd0:    p10 = 64'd1;
            2'd1:    p10 = 64'd10;
            2'd2:    p10 = 64'd100;
            default: p10 = 64'd1000;
          endcase
          work = (mag * p10) >> FRAC_BITS;
          ndig = int'(id) + int'(fd);
          if (ndig == 0) ndig = 1;
          if (ndig > MAX_DIGITS) ndig = MAX_DIGITS;
          field = 64'd0;
          for (k = 0; k < ndig; k++) begin
            nib = work % 64'd10;
            if (neg) nib = (64'd16 - nib) & 64'hF;
            field = field | (nib << (4 * k));
            work = work / 64'd10;
          end
          placed = (act == ACT_BCD6) ? (field << 6) : (field << 2);
          w = placed[23:0] & 24'h1FFFFC;
        end
      endcase
      if (^{lbl, w[22:0]} == 1'b0) w[23] = 1'b1;
      encode_word = w;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q.delete();
      err_cnt_o <= 0;
      pending_o <= 0;
      words_o   <= 0;
    end else begin
      if (done_i) begin
        words_o <= words_o + 1;
        if (word_q.size() == 0) begin
          $error("arinc_word: no word pending, got %06h", arinc_word_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          want = word_q.pop_front();
          if (want !== arinc_word_i) begin
            $error("arinc_word: expected %06h, actual %06h", want, arinc_word_i);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        word_q.push_back(encode_word(action_e'(action_i), value_fixed_i, int_digits_i,
                                     frac_digits_i, label_i));
      pending_o <= word_q.size();
    end
  end

endmodule

### bench/tb_arinc429_data_word_encoder_top.sv
// Top of the ARINC 429 data word encoder bench: clock, reset, item stimulus and verdict.
// Depends on a429e_pkg, arinc429_data_word_encoder_top and arinc429_word_checker.
`timescale 1ns / 1ps

module tb_arinc429_data_word_encoder_top;
  import a429e_pkg::*;

  localparam int NUM_ITEMS   = 950;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_TICKS = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  action;
  logic signed [31:0] value_fixed;
  logic [3:0]  int_digits;
  logic [1:0]  frac_digits;
  logic [7:0]  label;
  logic [23:0] arinc_word;
  logic        done;

  int err_cnt;
  int pending;
  int words;
  int n_items;
  int act_cnt[4];
  int idle_cnt;

  arinc429_data_word_encoder_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action),
    .value_fixed_i (value_fixed),
    .int_digits_i  (int_digits),
    .frac_digits_i (frac_digits),
    .label_i       (label),
    .arinc_word_o  (arinc_word),
    .done_o        (done)
  );

  arinc429_word_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .action_i      (action),
    .value_fixed_i (value_fixed),
    .int_digits_i  (int_digits),
    .frac_digits_i (frac_digits),
    .label_i       (label),
    .arinc_word_i  (arinc_word),
    .done_i        (done),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending),
    .words_o       (words)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input action_e act, input logic [31:0] v, input logic [3:0] id,
                           input logic [1:0] fd, input logic [7:0] lbl);
    begin
      @(negedge clk_i);
      start       = 1'b1;
      action      = act;
      value_fixed = v;
      int_digits  = id;
      frac_digits = fd;
      label       = lbl;
      do @(posedge clk_i); while (busy);
      n_items++;
      act_cnt[act]++;
    end
  endtask

  task automatic hold_off(input int n);
    begin
      if (n > 0) begin
        @(negedge clk_i);
        start = 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_drained;
    begin
      @(negedge clk_i);
      start = 1'b0;
      while (pending != 0) @(negedge clk_i);
    end
  endtask

  task automatic send_random_item;
    logic [31:0] v;
    logic [3:0]  id;
    int          pick;
    begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        v = $urandom;
      end else if (pick < 9) begin
        v = $urandom & ((32'd1 << $urandom_range(1, 31)) - 32'd1);
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end else begin
        case ($urandom_range(0, 5))
          0:       v = 32'h0000_0000;
          1:       v = 32'h0000_0001;
          2:       v = 32'h7FFF_FFFF;
          3:       v = 32'h8000_0000;
          4:       v = 32'hFFFF_FFFF;
          default: v = 32'h8000_0001;
        endcase
      end
      id = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      send_item(action_e'($urandom_range(0, 3)), v, id, 2'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int burst;
    int n_bursts;
    rst_ni      = 1'b0;
    start       = 1'b0;
    action      = ACT_BNR;
    value_fixed = '0;
    int_digits  = '0;
    frac_digits = '0;
    label       = '0;
    n_items     = 0;
    n_bursts    = 0;
    act_cnt     = '{default: 0};
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(ACT_BNR,  32'h0000_0000, 4'd0,  2'd0, 8'h00);
    send_item(ACT_BNR,  32'h0001_8000, 4'd0,  2'd0, 8'hFF);
    send_item(ACT_BNR,  32'hFFFE_8000, 4'd0,  2'd0, 8'h31);
    send_item(ACT_BNR,  32'h7FFF_FFFF, 4'd15, 2'd3, 8'h80);
    send_item(ACT_BNR,  32'h8000_0000, 4'd0,  2'd0, 8'h01);
    send_item(ACT_BNR,  32'hFFFF_FFFF, 4'd0,  2'd0, 8'h55);
    send_item(ACT_DEG,  32'h0000_0001, 4'd0,  2'd0, 8'h00);
    send_item(ACT_DEG,  32'h0000_FFFF, 4'd0,  2'd0, 8'hA5);
    send_item(ACT_DEG,  32'h7FFF_FFFF, 4'd0,  2'd0, 8'hFF);
    send_item(ACT_DEG,  32'h8000_0000, 4'd0,  2'd0, 8'h10);
    send_item(ACT_DEG,  32'hFFD2_0000, 4'd0,  2'd0, 8'h0F);
    send_item(ACT_BCD6, 32'h04D2_8000, 4'd4,  2'd1, 8'h22);
    send_item(ACT_BCD6, 32'hFB2D_8000, 4'd4,  2'd1, 8'h22);
    send_item(ACT_BCD6, 32'h0007_0000, 4'd0,  2'd0, 8'hC3);
    send_item(ACT_BCD6, 32'h7FFF_FFFF, 4'd15, 2'd3, 8'h00);
    send_item(ACT_BCD6, 32'h8000_0001, 4'd8,  2'd3, 8'hFF);
    send_item(ACT_BCD2, 32'h7FFF_0000, 4'd8,  2'd0, 8'h7E);
    send_item(ACT_BCD2, 32'h8000_0000, 4'd5,  2'd3, 8'h81);
    send_item(ACT_BCD2, 32'hFFFF_FFFF, 4'd2,  2'd2, 8'h3C);
    send_item(ACT_BCD2, 32'h0000_0000, 4'd3,  2'd0, 8'hAA);
    send_item(ACT_BCD2, 32'h0009_E666, 4'd1,  2'd3, 8'h01);
    wait_drained();

    while (n_items < NUM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) send_random_item();
      n_bursts++;
      if (n_bursts % 9 == 0) wait_drained();
      else if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 15));
    end

    wait_drained();
    repeat (DRAIN_TICKS) @(posedge clk_i);

    $display("Covered %0d items: BNR %0d, degree %0d, BCD6 %0d, BCD2 %0d; %0d words checked",
             n_items, act_cnt[0], act_cnt[1], act_cnt[2], act_cnt[3], words);
    if (err_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
